// File: hw/rtl/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Types, sizes and command codes of the parallel NOR flash command model.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int ARRAY_BYTES       = 65536;
    localparam int ARR_AW            = $clog2(ARRAY_BYTES);
    localparam int COMMAND_ADDR_BITS = 11;
    localparam int CMD_AW            = COMMAND_ADDR_BITS;

    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int CNT_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // command bus values
    localparam logic [CMD_AW-1:0] CMD_ADDR_UNLOCK1 = CMD_AW'(12'h555);
    localparam logic [CMD_AW-1:0] CMD_ADDR_UNLOCK2 = CMD_AW'(12'h2AA);
    localparam logic [DATA_W-1:0] CMD_UNLOCK1      = 8'hAA;
    localparam logic [DATA_W-1:0] CMD_UNLOCK2      = 8'h55;
    localparam logic [DATA_W-1:0] CMD_PROGRAM      = 8'hA0;
    localparam logic [DATA_W-1:0] CMD_AUTOSELECT   = 8'h90;
    localparam logic [DATA_W-1:0] CMD_ERASE_SETUP  = 8'h80;
    localparam logic [DATA_W-1:0] CMD_CHIP_ERASE   = 8'h10;
    localparam logic [DATA_W-1:0] CMD_RESET        = 8'hF0;
    localparam logic [DATA_W-1:0] ERASED_BYTE      = 8'hFF;

    typedef enum logic [0:0] {
        REQ_READ  = 1'b0,
        REQ_WRITE = 1'b1
    } req_type_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MANUFACTURER = 2'd0,
        CFG_DEVICE       = 2'd1,
        CFG_PROGRAM_BUSY = 2'd2,
        CFG_ERASE_BUSY   = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        PH_READ          = 4'd0,
        PH_UNLOCK1       = 4'd1,
        PH_UNLOCK2       = 4'd2,
        PH_PROGRAM       = 4'd3,
        PH_AUTOSEL       = 4'd4,
        PH_ERASE_SETUP   = 4'd5,
        PH_ERASE_UNLOCK1 = 4'd6,
        PH_ERASE_UNLOCK2 = 4'd7
    } phase_t;

    typedef enum logic [1:0] {
        CTL_CLEAR = 2'd0,
        CTL_IDLE  = 2'd1,
        CTL_EXEC  = 2'd2
    } ctl_state_t;

endpackage

// File: hw/rtl/pfc_req_if.sv
// ----------------------------------------------------------------------------
// pfc_req_if
// Bus access channel: one read or write word per handshake.
// ----------------------------------------------------------------------------
interface pfc_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [pfc_pkg::ADDR_W-1:0]  address;
    logic [pfc_pkg::DATA_W-1:0]  write_data;

    modport source (output valid, output req_type, output address, output write_data,
                    input ready);
    modport sink   (input valid, input req_type, input address, input write_data,
                    output ready);
endinterface

interface pfc_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [pfc_pkg::DATA_W-1:0]  read_data;
    logic                        busy_res;

    modport source (output valid, output read_data, output busy_res, input ready);
    modport sink   (input valid, input read_data, input busy_res, output ready);
endinterface

// File: hw/rtl/parallel_flash_command_model_core.sv
// ----------------------------------------------------------------------------
// parallel_flash_command_model_core
// Byte-wide NOR flash model: command decoder over a single-port array memory.
// ----------------------------------------------------------------------------
// Use: bus accesses enter on req (req_type 0 read, 1 write, address,
// write_data); each gives exactly one word on rsp (read_data, busy_res).
// Registers are loaded via cfg_we / cfg_index / cfg_wdata, by the user only while idle (unenforced).
// Timing: the result word is registered in the execute state. The array read is
// issued on the accept edge and its registered data is used in the
// following execute cycle, which also does the write-back of a program.
// A new access is taken only once the last has left the execute state, as
// that read-modify-write shares the one array memory port.
// Reset: the array memory is swept to 0xFF, one byte a cycle, over all
// ARRAY_BYTES (65536) bytes; req.ready stays low meanwhile. A chip erase
// runs the same sweep, its result word being issued before the sweep.
// Stall: the result word sits in an output register until rsp.ready; a
// new access is taken only once that register is free or being emptied.
// ----------------------------------------------------------------------------
module parallel_flash_command_model_core (
    input  logic                           clk,
    input  logic                           rst_n,
    pfc_req_if.sink                        req,
    pfc_rsp_if.source                      rsp,
    input  logic                           cfg_we,
    input  logic [pfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pfc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW = pfc_pkg::ARR_AW;
    localparam int DW = pfc_pkg::DATA_W;
    localparam int CW = pfc_pkg::CNT_W;

    // array memory
    logic [DW-1:0] mem [pfc_pkg::ARRAY_BYTES];
    logic [DW-1:0] rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;

    pfc_pkg::ctl_state_t state_reg, state_next;
    pfc_pkg::phase_t     phase_reg, phase_next;
    logic [CW-1:0]       busy_cnt_reg, busy_cnt_next;
    logic                toggle_reg, toggle_next;
    logic                poll_reg, poll_next;
    logic [AW-1:0]       clr_cnt_reg, clr_cnt_next;

    logic [DW-1:0]       manuf_reg, device_reg, prog_busy_reg;
    logic [CW-1:0]       erase_busy_reg;

    logic                         item_write_reg;
    logic [pfc_pkg::ADDR_W-1:0]   item_addr_reg;
    logic [DW-1:0]                item_data_reg;

    logic                out_valid_reg, out_valid_next;
    logic [DW-1:0]       out_data_reg, out_data_next;
    logic                out_busy_reg, out_busy_next;

    logic                accept;
    logic [AW-1:0]       idx_in;
    logic [AW-1:0]       idx_item;
    logic [pfc_pkg::CMD_AW-1:0] ca;
    logic                first_wr, second_wr;

    assign req.ready = (state_reg == pfc_pkg::CTL_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign idx_in    = AW'(req.address);
    assign idx_item  = AW'(item_addr_reg);
    assign ca        = item_addr_reg[pfc_pkg::CMD_AW-1:0];
    assign first_wr  = (ca == pfc_pkg::CMD_ADDR_UNLOCK1) && (item_data_reg == pfc_pkg::CMD_UNLOCK1);
    assign second_wr = (ca == pfc_pkg::CMD_ADDR_UNLOCK2) && (item_data_reg == pfc_pkg::CMD_UNLOCK2);

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;
    assign rsp.busy_res  = out_busy_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            rdata_reg <= mem[idx_in];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_write_reg <= req.req_type;
            item_addr_reg  <= req.address;
            item_data_reg  <= req.write_data;
        end
        out_data_reg <= out_data_next;
        out_busy_reg <= out_busy_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            manuf_reg      <= 8'h01;
            device_reg     <= 8'h20;
            prog_busy_reg  <= 8'd2;
            erase_busy_reg <= 16'd16;
        end
        else if (cfg_we)
        begin
            unique case (pfc_pkg::cfg_idx_t'(cfg_index))
                pfc_pkg::CFG_MANUFACTURER: manuf_reg      <= cfg_wdata[DW-1:0];
                pfc_pkg::CFG_DEVICE:       device_reg     <= cfg_wdata[DW-1:0];
                pfc_pkg::CFG_PROGRAM_BUSY: prog_busy_reg  <= cfg_wdata[DW-1:0];
                pfc_pkg::CFG_ERASE_BUSY:   erase_busy_reg <= cfg_wdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfc_pkg::CTL_CLEAR;
            phase_reg     <= pfc_pkg::PH_READ;
            busy_cnt_reg  <= '0;
            toggle_reg    <= 1'b0;
            poll_reg      <= 1'b0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            busy_cnt_reg  <= busy_cnt_next;
            toggle_reg    <= toggle_next;
            poll_reg      <= poll_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        busy_cnt_next  = busy_cnt_reg;
        toggle_next    = toggle_reg;
        poll_next      = poll_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_data_next  = out_data_reg;
        out_busy_next  = out_busy_reg;
        mem_we         = 1'b0;
        mem_waddr      = clr_cnt_reg;
        mem_wdata      = pfc_pkg::ERASED_BYTE;

        unique case (state_reg)
            pfc_pkg::CTL_CLEAR:
            begin
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(pfc_pkg::ARRAY_BYTES - 1))
                begin
                    state_next = pfc_pkg::CTL_IDLE;
                end
            end
            pfc_pkg::CTL_IDLE:
            begin
                if (accept)
                begin
                    state_next = pfc_pkg::CTL_EXEC;
                end
            end
            pfc_pkg::CTL_EXEC:
            begin
                state_next     = pfc_pkg::CTL_IDLE;
                out_valid_next = 1'b1;
                out_data_next  = '0;
                out_busy_next  = 1'b0;
                if (item_write_reg == pfc_pkg::REQ_WRITE)
                begin
                    // writes while busy are dropped
                    if (busy_cnt_reg == '0)
                    begin
                        unique case (phase_reg)
                            pfc_pkg::PH_PROGRAM:
                            begin
                                mem_we        = 1'b1;
                                mem_waddr     = idx_item;
                                mem_wdata     = rdata_reg & item_data_reg;
                                poll_next     = ~item_data_reg[DW-1];
                                busy_cnt_next = CW'(prog_busy_reg);
                                phase_next    = pfc_pkg::PH_READ;
                            end
                            pfc_pkg::PH_READ:
                                phase_next = first_wr ? pfc_pkg::PH_UNLOCK1 : pfc_pkg::PH_READ;
                            pfc_pkg::PH_AUTOSEL:
                            begin
                                if (item_data_reg == pfc_pkg::CMD_RESET)
                                    phase_next = pfc_pkg::PH_READ;
                                else if (first_wr)
                                    phase_next = pfc_pkg::PH_UNLOCK1;
                            end
                            pfc_pkg::PH_UNLOCK1:
                                phase_next = second_wr ? pfc_pkg::PH_UNLOCK2 : pfc_pkg::PH_READ;
                            pfc_pkg::PH_UNLOCK2:
                            begin
                                phase_next = pfc_pkg::PH_READ;
                                if (ca == pfc_pkg::CMD_ADDR_UNLOCK1)
                                begin
                                    priority if (item_data_reg == pfc_pkg::CMD_PROGRAM)
                                        phase_next = pfc_pkg::PH_PROGRAM;
                                    else if (item_data_reg == pfc_pkg::CMD_AUTOSELECT)
                                        phase_next = pfc_pkg::PH_AUTOSEL;
                                    else if (item_data_reg == pfc_pkg::CMD_ERASE_SETUP)
                                        phase_next = pfc_pkg::PH_ERASE_SETUP;
                                    else
                                        phase_next = pfc_pkg::PH_READ;
                                end
                            end
                            pfc_pkg::PH_ERASE_SETUP:
                                phase_next = first_wr ? pfc_pkg::PH_ERASE_UNLOCK1
                                                      : pfc_pkg::PH_READ;
                            pfc_pkg::PH_ERASE_UNLOCK1:
                                phase_next = second_wr ? pfc_pkg::PH_ERASE_UNLOCK2
                                                       : pfc_pkg::PH_READ;
                            pfc_pkg::PH_ERASE_UNLOCK2:
                            begin
                                phase_next = pfc_pkg::PH_READ;
                                if ((ca == pfc_pkg::CMD_ADDR_UNLOCK1) &&
                                    (item_data_reg == pfc_pkg::CMD_CHIP_ERASE))
                                begin
                                    poll_next     = 1'b0;
                                    busy_cnt_next = erase_busy_reg;
                                    clr_cnt_next  = '0;
                                    state_next    = pfc_pkg::CTL_CLEAR;
                                end
                            end
                            default:
                                phase_next = pfc_pkg::PH_READ;
                        endcase
                    end
                    out_busy_next = (busy_cnt_next != '0);
                end
                else if (busy_cnt_reg != '0)
                begin
                    // status read: DQ7 polling, DQ6 toggle
                    out_data_next = {poll_reg, toggle_reg, 6'b0};
                    out_busy_next = 1'b1;
                    toggle_next   = ~toggle_reg;
                    busy_cnt_next = busy_cnt_reg - CW'(1);
                end
                else if (phase_reg == pfc_pkg::PH_AUTOSEL)
                begin
                    unique case (item_addr_reg[1:0])
                        2'd0:    out_data_next = manuf_reg;
                        2'd1:    out_data_next = device_reg;
                        default: out_data_next = '0;
                    endcase
                end
                else
                begin
                    out_data_next = rdata_reg;
                end
            end
            default:
                state_next = pfc_pkg::CTL_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 out_valid_reg)
        else $error("accepted access gave no result word");

    a_status_countdown: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pfc_pkg::CTL_EXEC && item_write_reg == pfc_pkg::REQ_READ &&
         busy_cnt_reg != '0) |=> (busy_cnt_reg == $past(busy_cnt_reg) - CW'(1)))
        else $error("status read did not count down");

    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pfc_pkg::CTL_CLEAR) |-> !accept)
        else $error("access taken during array sweep");

    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == pfc_pkg::CTL_CLEAR || state_reg == pfc_pkg::CTL_EXEC))
        else $error("array written outside sweep or execute");
`endif

endmodule
